// ===== rtl/core/rtcte_pkg.sv =====
// Shared package for the clock-chip snapshot to epoch-seconds converter.
// Holds pipeline depth, calendar constants, register indexes and the byte decode.
// No dependencies.
package rtcte_pkg;

   // pipeline depth, output register included
   localparam int NumStages = 7;

   // configuration register indexes
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrBcdMode   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrHour24Mode = 2'd1;

   // calendar constants
   localparam logic [7:0]  HourNoon    = 8'd12;
   localparam logic [7:0]  MonthsYear  = 8'd12;
   localparam logic [14:0] YearBias    = 15'd399;     // year - 1 + 400
   localparam logic [12:0] Recip25     = 13'd5243;    // ceil(2^17 / 25)
   localparam int          RecipShift  = 17;
   // 146097 (400-year bias) + 719162 (days before 1970) + 1 (day - 1)
   localparam logic [31:0] DayOffset   = 32'd865260;
   localparam logic [31:0] SecPerDay   = 32'd86400;

   typedef struct packed {
      logic [NumStages-1:0] load;
      logic [NumStages-1:0] valid;
   } pipe_ctl_type;

   // BCD: high nibble times ten plus low nibble, non-decimal nibbles kept as weighted
   function automatic logic [7:0] decode_byte(input logic bcd, input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'b0000, b[7:4]};
      if (bcd) begin
         return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
      end
      return b;
   endfunction

   // days before the first of month (index 0 = January, 12 = full year)
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] d;
      unique case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd365;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/core/rtcte_pipe_ctl.sv =====
// Valid and load control for the converter pipeline, stalls propagate per stage.
// Depends on rtcte_pkg (NumStages, pipe_ctl_type).
module rtcte_pipe_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_stall,
   output rtcte_pkg::pipe_ctl_type ctl
);

   logic [rtcte_pkg::NumStages-1:0] valid_ff;
   logic [rtcte_pkg::NumStages-1:0] valid_in;
   logic [rtcte_pkg::NumStages-1:0] load;

   // a stage loads when empty or when the stage after it moves on
   always_comb begin
      load[rtcte_pkg::NumStages-1] = !valid_ff[rtcte_pkg::NumStages-1] || !out_stall;
      for (int k = rtcte_pkg::NumStages - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < rtcte_pkg::NumStages; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = load;
   assign ctl.valid = valid_ff;

endmodule

// ===== rtl/core/rtc_time_to_epoch_seconds.sv =====
// Converts raw clock-chip date and time bytes to 32-bit Unix seconds.
// Depends on rtcte_pkg and rtcte_pipe_ctl.
//
// Usage:
//   Input channel req_*: one snapshot (century, year, month, day, hour,
//   minute, second bytes) is taken at an edge with req_valid high and
//   req_stall low. Result channel rsp_*: rsp_epoch_seconds is taken at an
//   edge with rsp_valid high and rsp_stall low.
//   Config channel csr_*: csr_ready is always high; index 0 = bcd_mode,
//   index 1 = hour_24_mode, bit 0 of csr_wdata is written. Write only
//   while the pipeline is empty.
// Timing:
//   Seven register stages (decode, year, reciprocal divide by 100, day
//   and time-of-day sums, epoch offset, day multiply, final add). rsp_valid
//   rises once an item reaches the final add register; one item per cycle
//   while req_stall is low.
// Reset: empties the pipeline and sets both mode bits to 1 (BCD, 24-hour).
// Stall: when rsp_stall holds a result, stages behind it keep filling
//   their bubbles; req_stall rises only once every stage holds an item.
module rtc_time_to_epoch_seconds (
   input  logic                                 clock,
   input  logic                                 reset,
   // input snapshot
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_raw_century,
   input  logic [7:0]                           req_raw_year,
   input  logic [7:0]                           req_raw_month,
   input  logic [7:0]                           req_raw_day,
   input  logic [7:0]                           req_raw_hour,
   input  logic [7:0]                           req_raw_minute,
   input  logic [7:0]                           req_raw_second,
   // result
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [31:0]                          rsp_epoch_seconds,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rtcte_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic                                 csr_wdata
);

   rtcte_pkg::pipe_ctl_type ctl;

   // ---------------- configuration ----------------
   logic bcd_mode_ff, bcd_mode_in;
   logic hour_24_mode_ff, hour_24_mode_in;
   logic csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      bcd_mode_in     = bcd_mode_ff;
      hour_24_mode_in = hour_24_mode_ff;
      if (csr_write) begin
         unique case (csr_index)
            rtcte_pkg::CsrBcdMode:    bcd_mode_in     = csr_wdata;
            rtcte_pkg::CsrHour24Mode: hour_24_mode_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_mode_ff     <= 1'b1;
         hour_24_mode_ff <= 1'b1;
      end else begin
         bcd_mode_ff     <= bcd_mode_in;
         hour_24_mode_ff <= hour_24_mode_in;
      end
   end

   // ---------------- pipeline control ----------------
   rtcte_pipe_ctl u_pipe_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .ctl       (ctl)
   );

   assign req_stall = !ctl.load[0];
   assign rsp_valid = ctl.valid[rtcte_pkg::NumStages-1];

   // ---------------- stage 1: byte decode, hour fixup, month index ----------------
   logic [7:0] s1_cent_ff, s1_cent_in;
   logic [7:0] s1_year_ff, s1_year_in;
   logic [3:0] s1_idx_ff, s1_idx_in;
   logic [7:0] s1_day_ff, s1_day_in;
   logic [7:0] s1_hour_ff, s1_hour_in;
   logic [7:0] s1_min_ff, s1_min_in;
   logic [7:0] s1_sec_ff, s1_sec_in;
   logic [7:0] month_dec;
   logic [7:0] hour_12;

   assign s1_cent_in = rtcte_pkg::decode_byte(bcd_mode_ff, req_raw_century);
   assign s1_year_in = rtcte_pkg::decode_byte(bcd_mode_ff, req_raw_year);
   assign s1_day_in  = rtcte_pkg::decode_byte(bcd_mode_ff, req_raw_day);
   assign s1_min_in  = rtcte_pkg::decode_byte(bcd_mode_ff, req_raw_minute);
   assign s1_sec_in  = rtcte_pkg::decode_byte(bcd_mode_ff, req_raw_second);
   assign month_dec  = rtcte_pkg::decode_byte(bcd_mode_ff, req_raw_month);
   // PM flag stripped before decode in 12-hour mode
   assign hour_12    = rtcte_pkg::decode_byte(bcd_mode_ff, {1'b0, req_raw_hour[6:0]});

   // month zero counts no months, above twelve counts a full year
   always_comb begin
      priority if (month_dec == 8'd0) begin
         s1_idx_in = 4'd0;
      end else if (month_dec > rtcte_pkg::MonthsYear) begin
         s1_idx_in = rtcte_pkg::MonthsYear[3:0];
      end else begin
         s1_idx_in = 4'(month_dec - 8'd1);
      end
   end

   // 12 AM is hour 0, 12 PM stays 12, other PM hours add 12
   always_comb begin
      priority if (hour_24_mode_ff) begin
         s1_hour_in = rtcte_pkg::decode_byte(bcd_mode_ff, req_raw_hour);
      end else if (hour_12 == rtcte_pkg::HourNoon) begin
         s1_hour_in = req_raw_hour[7] ? rtcte_pkg::HourNoon : 8'd0;
      end else begin
         s1_hour_in = req_raw_hour[7] ? hour_12 + rtcte_pkg::HourNoon : hour_12;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s1_cent_ff <= s1_cent_in;
         s1_year_ff <= s1_year_in;
         s1_idx_ff  <= s1_idx_in;
         s1_day_ff  <= s1_day_in;
         s1_hour_ff <= s1_hour_in;
         s1_min_ff  <= s1_min_in;
         s1_sec_ff  <= s1_sec_in;
      end
   end

   // ---------------- stage 2: full year, month start days ----------------
   logic [14:0] s2_year_ff, s2_year_in;
   logic [8:0]  s2_ms_ff, s2_ms_in;
   logic [7:0]  s2_day_ff, s2_hour_ff, s2_min_ff, s2_sec_ff;

   assign s2_year_in = 15'(s1_cent_ff) * 15'd100 + 15'(s1_year_ff);
   assign s2_ms_in   = rtcte_pkg::month_start(s1_idx_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s2_year_ff <= s2_year_in;
         s2_ms_ff   <= s2_ms_in;
         s2_day_ff  <= s1_day_ff;
         s2_hour_ff <= s1_hour_ff;
         s2_min_ff  <= s1_min_ff;
         s2_sec_ff  <= s1_sec_ff;
      end
   end

   // ---------------- stage 3: divide by 100 through reciprocal of 25 ----------------
   logic [14:0] s3_n_ff, s3_n_in;
   logic [14:0] s3_year_ff;
   logic [8:0]  s3_qn_ff, s3_qn_in;
   logic [8:0]  s3_qy_ff, s3_qy_in;
   logic [8:0]  s3_ms_ff;
   logic [7:0]  s3_day_ff, s3_hour_ff, s3_min_ff, s3_sec_ff;
   logic [25:0] qn_prod, qy_prod;

   assign s3_n_in  = s2_year_ff + rtcte_pkg::YearBias;
   // x / 100 = (x >> 2) / 25, exact for (x >> 2) below 43690
   assign qn_prod  = 26'(s3_n_in[14:2]) * 26'(rtcte_pkg::Recip25);
   assign qy_prod  = 26'(s2_year_ff[14:2]) * 26'(rtcte_pkg::Recip25);
   assign s3_qn_in = qn_prod[rtcte_pkg::RecipShift +: 9];
   assign s3_qy_in = qy_prod[rtcte_pkg::RecipShift +: 9];

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s3_n_ff    <= s3_n_in;
         s3_year_ff <= s2_year_ff;
         s3_qn_ff   <= s3_qn_in;
         s3_qy_ff   <= s3_qy_in;
         s3_ms_ff   <= s2_ms_ff;
         s3_day_ff  <= s2_day_ff;
         s3_hour_ff <= s2_hour_ff;
         s3_min_ff  <= s2_min_ff;
         s3_sec_ff  <= s2_sec_ff;
      end
   end

   // ---------------- stage 4: leap rule, whole-year days, time of day ----------------
   logic [23:0] s4_dby_ff, s4_dby_in;
   logic        s4_leap_ff, s4_leap_in;
   logic [19:0] s4_tod_ff, s4_tod_in;
   logic [8:0]  s4_ms_ff;
   logic [7:0]  s4_day_ff;
   logic [14:0] year_rem100;

   assign year_rem100 = s3_year_ff - 15'(s3_qy_ff) * 15'd100;
   // leap adjustment applies only once February is past
   assign s4_leap_in  = (s3_year_ff[1:0] == 2'b00)
                      && ((year_rem100 != 15'd0) || (s3_qy_ff[1:0] == 2'b00))
                      && (s3_ms_ff >= rtcte_pkg::month_start(4'd2));
   // 365 n + n/4 - n/100 + n/400, bias constant folded in later
   assign s4_dby_in   = 24'(s3_n_ff) * 24'd365 + 24'(s3_n_ff[14:2])
                      - 24'(s3_qn_ff) + 24'(s3_qn_ff[8:2]);
   assign s4_tod_in   = 20'(s3_hour_ff) * 20'd3600 + 20'(s3_min_ff) * 20'd60
                      + 20'(s3_sec_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s4_dby_ff  <= s4_dby_in;
         s4_leap_ff <= s4_leap_in;
         s4_tod_ff  <= s4_tod_in;
         s4_ms_ff   <= s3_ms_ff;
         s4_day_ff  <= s3_day_ff;
      end
   end

   // ---------------- stage 5: day count from the epoch, modulo 2^32 ----------------
   logic [31:0] s5_days_ff, s5_days_in;
   logic [19:0] s5_tod_ff;

   assign s5_days_in = 32'(s4_dby_ff) + 32'(s4_ms_ff) + 32'(s4_day_ff)
                     + 32'(s4_leap_ff) - rtcte_pkg::DayOffset;

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         s5_days_ff <= s5_days_in;
         s5_tod_ff  <= s4_tod_ff;
      end
   end

   // ---------------- stage 6: days to seconds ----------------
   logic [31:0] s6_prod_ff, s6_prod_in;
   logic [19:0] s6_tod_ff;

   assign s6_prod_in = s5_days_ff * rtcte_pkg::SecPerDay;

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         s6_prod_ff <= s6_prod_in;
         s6_tod_ff  <= s5_tod_ff;
      end
   end

   // ---------------- stage 7: output register ----------------
   logic [31:0] s7_secs_ff, s7_secs_in;

   assign s7_secs_in = s6_prod_ff + 32'(s6_tod_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         s7_secs_ff <= s7_secs_in;
      end
   end

   assign rsp_epoch_seconds = s7_secs_ff;

   // ---------------- assertions ----------------
`ifndef SYNTH
   // an item next to the output moves into it unless the output is held
   a_advance: assert property (@(posedge clock) disable iff (reset)
      ctl.valid[rtcte_pkg::NumStages-2] && !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("pipeline item failed to reach output register");

   // input is only held back once every stage is occupied
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !(&ctl.valid) |-> !req_stall)
      else $error("input stalled while pipeline has a bubble");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // mode register takes the written bit
   a_bcd_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == rtcte_pkg::CsrBcdMode)
      |=> bcd_mode_ff == $past(csr_wdata))
      else $error("bcd mode write lost");
`endif

endmodule

// ===== tb/sv/epoch_seconds_checker.sv =====
// Checker for rtc_time_to_epoch_seconds: tracks the mode registers, predicts the epoch
// seconds of every accepted snapshot and compares results in order.
// Depends on rtcte_pkg for the register index constants.
module epoch_seconds_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [7:0]                           req_raw_century,
   input  logic [7:0]                           req_raw_year,
   input  logic [7:0]                           req_raw_month,
   input  logic [7:0]                           req_raw_day,
   input  logic [7:0]                           req_raw_hour,
   input  logic [7:0]                           req_raw_minute,
   input  logic [7:0]                           req_raw_second,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [31:0]                          rsp_epoch_seconds,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [rtcte_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic                                 csr_wdata,
   input  logic                                 end_of_run,
   output int                                   mismatch_count,
   output int                                   pending_count,
   output int                                   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // days before the first of each month, last entry is a full common year
   int month_start_days [0:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

   logic        bcd_sel = 1'b1;
   logic        hour24_sel = 1'b1;
   logic [31:0] expected_seconds_q [$];
   int          errs = 0;
   int          compared = 0;
   bit          leftovers_done = 1'b0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
   end

   function automatic int decode_raw(input logic bcd, input logic [7:0] b);
      // non-decimal nibbles keep their weight, so BCD gives 0..165
      if (bcd) begin
         return int'(b[7:4]) * 10 + int'(b[3:0]);
      end
      return int'(b);
   endfunction

   // whole days in years 1..y-1, proleptic Gregorian, biased by 400 years to stay positive
   function automatic longint days_before_year(input longint y);
      longint n;
      n = y + 399;
      return 365 * n + n / 4 - n / 100 + n / 400 - 146097;
   endfunction

   function automatic logic [31:0] predict_epoch_seconds(
      input logic [7:0] cen, yr, mon, dy, hr, mnt, sec,
      input logic       bcd, hour24
   );
      longint year, days, hour, total;
      int     month, month_idx, h;
      year  = longint'(decode_raw(bcd, cen)) * 100 + decode_raw(bcd, yr);
      month = decode_raw(bcd, mon);
      // 12-hour form: strip PM flag, then 12 AM is midnight and 12 PM stays noon
      if (hour24) begin
         hour = decode_raw(bcd, hr);
      end else begin
         h = decode_raw(bcd, {1'b0, hr[6:0]});
         if (hr[7]) begin
            hour = (h == 12) ? 12 : h + 12;
         end else begin
            hour = (h == 12) ? 0 : h;
         end
      end
      // month zero: nothing elapsed; above twelve: a full year elapsed
      month_idx = (month == 0) ? 0 : ((month > 12) ? 12 : month - 1);
      days = days_before_year(year) + month_start_days[month_idx]
           + longint'(decode_raw(bcd, dy)) - 1;
      if (month_idx >= 2 && (((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0))) begin
         days = days + 1;
      end
      days  = days - days_before_year(1970);
      total = days * 86400 + hour * 3600 + longint'(decode_raw(bcd, mnt)) * 60
            + decode_raw(bcd, sec);
      return total[31:0];
   endfunction

   task automatic note_mismatch(input string msg);
      errs++;
      if (errs <= 10) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endtask

   // everything sampled at the rising edge; results are popped before new items are pushed
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         bcd_sel    = 1'b1;
         hour24_sel = 1'b1;
         expected_seconds_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_seconds_q.size() == 0) begin
               note_mismatch($sformatf("unexpected result 0x%08h with nothing pending",
                                       rsp_epoch_seconds));
            end else begin
               want = expected_seconds_q.pop_front();
               compared++;
               if (rsp_epoch_seconds !== want) begin
                  note_mismatch($sformatf("result %0d epoch_seconds expected 0x%08h got 0x%08h",
                                          compared, want, rsp_epoch_seconds));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_seconds_q.push_back(predict_epoch_seconds(
               req_raw_century, req_raw_year, req_raw_month, req_raw_day,
               req_raw_hour, req_raw_minute, req_raw_second, bcd_sel, hour24_sel));
         end
         // mode writes apply to items accepted after this edge
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rtcte_pkg::CsrBcdMode: begin
                  bcd_sel = csr_wdata;
               end
               rtcte_pkg::CsrHour24Mode: begin
                  hour24_sel = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (end_of_run && !leftovers_done) begin
            leftovers_done = 1'b1;
            foreach (expected_seconds_q[i]) begin
               note_mismatch($sformatf("expected 0x%08h never arrived", expected_seconds_q[i]));
            end
         end
      end
      mismatch_count <= errs;
      pending_count  <= expected_seconds_q.size();
      checked_count  <= compared;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the rtc_time_to_epoch_seconds testbench: clock, reset, stimulus and verdict.
// Depends on rtcte_pkg, the block itself and epoch_seconds_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [7:0]                           req_raw_century = '0;
   logic [7:0]                           req_raw_year = '0;
   logic [7:0]                           req_raw_month = '0;
   logic [7:0]                           req_raw_day = '0;
   logic [7:0]                           req_raw_hour = '0;
   logic [7:0]                           req_raw_minute = '0;
   logic [7:0]                           req_raw_second = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [31:0]                          rsp_epoch_seconds;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [rtcte_pkg::CsrIndexWidth-1:0]  csr_index = '0;
   logic                                 csr_wdata = 1'b0;
   logic                                 end_of_run = 1'b0;
   int                                   mismatch_count;
   int                                   pending_count;
   int                                   checked_count;

   int   send_gap_pct = 7;
   int   rsp_stall_pct = 7;
   int   sent_count = 0;
   logic cur_bcd = 1'b1;
   logic cur_hour24 = 1'b1;

   rtc_time_to_epoch_seconds i_dut (.*);

   epoch_seconds_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side backpressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results still pending", pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [7:0] encode_field(input logic bcd, input int v);
      if (bcd) begin
         return {4'(v / 10), 4'(v % 10)};
      end
      return 8'(v);
   endfunction

   // one snapshot, with an occasional gap in front of it
   task automatic send_snapshot(input logic [7:0] cen, yr, mon, dy, hr, mnt, sec);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_raw_century <= cen;
      req_raw_year    <= yr;
      req_raw_month   <= mon;
      req_raw_day     <= dy;
      req_raw_hour    <= hr;
      req_raw_minute  <= mnt;
      req_raw_second  <= sec;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // hold off the sender until every pending result is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (rtcte_pkg::NumStages) @(negedge clock);
   endtask

   task automatic write_csr(input logic [rtcte_pkg::CsrIndexWidth-1:0] idx, input logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_modes(input logic bcd, input logic hour24);
      wait_drained();
      write_csr(rtcte_pkg::CsrBcdMode, bcd);
      write_csr(rtcte_pkg::CsrHour24Mode, hour24);
      cur_bcd    = bcd;
      cur_hour24 = hour24;
   endtask

   // mostly plausible dates in the current encoding, some raw noise
   task automatic send_random();
      logic [7:0] cen, yr, mon, dy, hr, mnt, sec;
      if ($urandom_range(0, 99) < 20) begin
         cen = 8'($urandom_range(0, 255));
         yr  = 8'($urandom_range(0, 255));
         mon = 8'($urandom_range(0, 255));
         dy  = 8'($urandom_range(0, 255));
         hr  = 8'($urandom_range(0, 255));
         mnt = 8'($urandom_range(0, 255));
         sec = 8'($urandom_range(0, 255));
      end else begin
         cen = encode_field(cur_bcd, ($urandom_range(0, 9) == 0) ?
                                     $urandom_range(0, 99) : $urandom_range(19, 21));
         yr  = encode_field(cur_bcd, $urandom_range(0, 99));
         mon = encode_field(cur_bcd, $urandom_range(1, 12));
         dy  = encode_field(cur_bcd, $urandom_range(1, 31));
         if (cur_hour24) begin
            hr = encode_field(cur_bcd, $urandom_range(0, 23));
         end else begin
            hr    = encode_field(cur_bcd, $urandom_range(1, 12));
            hr[7] = 1'($urandom_range(0, 1));
         end
         mnt = encode_field(cur_bcd, $urandom_range(0, 59));
         sec = encode_field(cur_bcd, $urandom_range(0, 59));
      end
      send_snapshot(cen, yr, mon, dy, hr, mnt, sec);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // BCD, 24-hour (reset modes): epoch, 32-bit limits and calendar corners
      send_snapshot(8'h19, 8'h70, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
      send_snapshot(8'h20, 8'h38, 8'h01, 8'h19, 8'h03, 8'h14, 8'h07);
      send_snapshot(8'h20, 8'h38, 8'h01, 8'h19, 8'h03, 8'h14, 8'h08);
      send_snapshot(8'h21, 8'h06, 8'h02, 8'h07, 8'h06, 8'h28, 8'h16);
      send_snapshot(8'h20, 8'h00, 8'h02, 8'h29, 8'h23, 8'h59, 8'h59);
      send_snapshot(8'h20, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00);
      send_snapshot(8'h19, 8'h00, 8'h03, 8'h01, 8'h12, 8'h00, 8'h00);
      send_snapshot(8'h20, 8'h24, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);
      send_snapshot(8'h20, 8'h24, 8'h00, 8'h15, 8'h10, 8'h30, 8'h00);
      send_snapshot(8'h20, 8'h24, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00);
      send_snapshot(8'h20, 8'h23, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00);
      send_snapshot(8'h20, 8'h23, 8'h02, 8'h31, 8'h00, 8'h00, 8'h00);
      send_snapshot(8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
      send_snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_snapshot(8'h20, 8'h10, 8'h06, 8'h15, 8'h80, 8'h99, 8'h9A);

      // BCD, 12-hour: midnight, noon, afternoon, morning, PM flag on garbage
      set_modes(1'b1, 1'b0);
      send_snapshot(8'h20, 8'h20, 8'h05, 8'h05, 8'h12, 8'h00, 8'h01);
      send_snapshot(8'h20, 8'h20, 8'h05, 8'h05, 8'h92, 8'h00, 8'h01);
      send_snapshot(8'h20, 8'h20, 8'h05, 8'h05, 8'h81, 8'h00, 8'h01);
      send_snapshot(8'h20, 8'h20, 8'h05, 8'h05, 8'h11, 8'h59, 8'h59);
      send_snapshot(8'h20, 8'h20, 8'h05, 8'h05, 8'hFF, 8'h00, 8'h00);

      // binary, 24-hour
      set_modes(1'b0, 1'b1);
      send_snapshot(8'd19, 8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
      send_snapshot(8'd20, 8'd38, 8'd1, 8'd19, 8'd3, 8'd14, 8'd7);
      send_snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

      // random: a stretch with no idling on either side first
      set_modes(1'b1, 1'b1);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      repeat (200) send_random();
      send_gap_pct  = 7;
      rsp_stall_pct = 7;
      repeat (200) send_random();
      wait_drained();
      repeat (100) send_random();

      set_modes(1'b0, 1'b1);
      repeat (350) send_random();

      set_modes(1'b1, 1'b0);
      repeat (350) send_random();

      // heavy result backpressure fills the pipeline so req_stall rises
      set_modes(1'b0, 1'b0);
      rsp_stall_pct = 60;
      repeat (150) send_random();
      rsp_stall_pct = 7;
      repeat (250) send_random();

      wait_drained();
      repeat (rtcte_pkg::NumStages + 4) @(negedge clock);
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);

      $display("Covered %0d snapshots over all BCD/binary and 12/24-hour settings,", sent_count);
      $display("calendar corners, 32-bit wrap and raw noise; %0d results compared, %0d mismatches",
               checked_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== rtc_time_to_epoch_seconds.f =====
rtl/core/rtcte_pkg.sv
rtl/core/rtcte_pipe_ctl.sv
rtl/core/rtc_time_to_epoch_seconds.sv
tb/sv/epoch_seconds_checker.sv
tb/sv/tb_top.sv
